// ===== hw/rtl/abkd_pkg.sv =====
// Shared types, tables and arithmetic helpers for the anchor box keypoint decoder.
package abkd_pkg;

  localparam logic [15:0] SIG_TAB [25] = '{
    16'd32768, 16'd40793, 16'd47911, 16'd53580, 16'd57724, 16'd60565, 16'd62428,
    16'd63615, 16'd64357, 16'd64816, 16'd65097, 16'd65269, 16'd65374, 16'd65438,
    16'd65476, 16'd65500, 16'd65514, 16'd65523, 16'd65528, 16'd65531, 16'd65533,
    16'd65534, 16'd65535, 16'd65535, 16'd65535};

  localparam logic [8:0] ANCHOR_TAB [3][18] = '{
    '{9'd6, 9'd5, 9'd9, 9'd7, 9'd13, 9'd9, 9'd18, 9'd15, 9'd30, 9'd23, 9'd46, 9'd37,
      9'd60, 9'd52, 9'd94, 9'd56, 9'd125, 9'd72},
    '{9'd26, 9'd27, 9'd28, 9'd28, 9'd27, 9'd30, 9'd29, 9'd29, 9'd29, 9'd32, 9'd30, 9'd31,
      9'd30, 9'd33, 9'd32, 9'd32, 9'd32, 9'd34},
    '{9'd11, 9'd10, 9'd19, 9'd15, 9'd28, 9'd22, 9'd39, 9'd34, 9'd64, 9'd48, 9'd92, 9'd76,
      9'd132, 9'd110, 9'd197, 9'd119, 9'd265, 9'd162}};

  localparam logic [2:0] KP_ALWAYS_KEPT = 3'd2;

  // config register indexes
  localparam logic CFG_STRIDE = 1'b0;
  localparam logic CFG_THRESH = 1'b1;

  typedef enum logic [3:0] {
    B_IDLE, B_OBJ, B_CLS, B_CONF, B_SX, B_SY, B_SW, B_SH,
    B_W1, B_W2, B_H1, B_H2, B_BOX, B_KX, B_KY, B_KEMIT
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Q8.8 logit to Q0.16 probability, table plus linear interpolation.
  function automatic logic [15:0] sigm(input logic [15:0] raw);
    logic [15:0] a;
    logic [8:0]  i;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [22:0] prod;
    logic [15:0] p;
    logic [16:0] n;
    a = raw[15] ? (~raw + 16'd1) : raw;
    i = a[15:7];
    lo = 16'd0;
    hi = 16'd0;
    prod = 23'd0;
    if (i >= 9'd24) begin
      p = 16'hFFFF;
    end else begin
      lo = SIG_TAB[i[4:0]];
      hi = SIG_TAB[i[4:0] + 5'd1];
      prod = {7'd0, hi - lo} * {16'd0, a[6:0]};
      p = lo + prod[22:7];
    end
    n = 17'h10000 - {1'b0, p};
    return raw[15] ? n[15:0] : p;
  endfunction

  // Q.16 to Q.4 with floor, saturated to 20 bits signed.
  function automatic logic [19:0] sat_q4(input logic signed [32:0] v);
    logic signed [32:0] r;
    r = v >>> 12;
    if (r > 33'sd524287) return 20'h7FFFF;
    else if (r < -33'sd524288) return 20'h80000;
    else return r[19:0];
  endfunction

endpackage

// ===== hw/rtl/anchor_box_keypoint_decode.sv =====
// Top level of the pose head decoder: config registers, front, cell queue and back.
// One logit is taken per cycle while in_stall is low; a cell spans 5 + CLASS_COUNT + 3 * KEYPOINT_COUNT
// logits. The front packs each finished cell into a two-entry queue, and in_stall
// is high only while that queue is full. The back sequencer reuses one sigmoid
// unit, so a kept cell takes longer in the back than its logits take to arrive,
// plus any output stall; a long run of kept cells stalls the input once the queue
// is full, while dropped cells keep up with one logit per cycle.
module anchor_box_keypoint_decode #(
  parameter int CLASS_COUNT = 4,
  parameter int KEYPOINT_COUNT = 5,
  parameter int ANCHORS_PER_CELL = 3,
  parameter int IMAGE_SIZE = 640
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] logit,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [19:0] pos_x,
  output logic [19:0] pos_y,
  output logic [14:0] box_width,
  output logic [14:0] box_height,
  output logic [3:0]  class_index,
  output logic [15:0] confidence,
  output logic [2:0]  keypoint_index,
  output logic        last
);

  localparam int CHANNELS = 5 + CLASS_COUNT + 3 * KEYPOINT_COUNT;
  localparam int REC_W = CHANNELS * 16 + 35;
  localparam int ANCHOR_SET = (IMAGE_SIZE == 320) ? 0 : ((IMAGE_SIZE == 416) ? 1 : 2);

  logic [2:0]  stride_log2;
  logic [15:0] score_thresh;
  logic        q_push;
  logic        q_pop;
  logic [REC_W-1:0] q_in;
  logic [REC_W-1:0] q_head;
  abkd_pkg::queue_status_t q_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      stride_log2 <= 3'd3;
      score_thresh <= 16'd32768;
    end else if (cfg_write) begin
      if (cfg_index == abkd_pkg::CFG_STRIDE) stride_log2 <= cfg_data[2:0];
      if (cfg_index == abkd_pkg::CFG_THRESH) score_thresh <= cfg_data;
    end
  end

  abkd_front #(
    .CHANNELS(CHANNELS), .ANCHORS_PER_CELL(ANCHORS_PER_CELL),
    .IMAGE_SIZE(IMAGE_SIZE), .REC_W(REC_W)
  ) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .logit(logit), .frame_start(frame_start), .stride_log2(stride_log2),
    .score_thresh(score_thresh), .q_full(q_status.full),
    .push(q_push), .rec(q_in)
  );

  abkd_queue #(.WIDTH(REC_W)) u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_data(q_in),
    .pop(q_pop), .head(q_head), .status(q_status)
  );

  abkd_back #(
    .CHANNELS(CHANNELS), .CLASS_COUNT(CLASS_COUNT), .KEYPOINT_COUNT(KEYPOINT_COUNT),
    .ANCHOR_SET(ANCHOR_SET), .REC_W(REC_W)
  ) u_back (
    .clk(clk), .rst(rst), .rec(q_head), .q_status(q_status), .pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
    .pos_x(pos_x), .pos_y(pos_y), .box_width(box_width), .box_height(box_height),
    .class_index(class_index), .confidence(confidence),
    .keypoint_index(keypoint_index), .last(last)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full) else $error("cell pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty) else $error("cell popped from empty queue");
  a_box_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !kind) |-> (!last && keypoint_index == 3'd0))
    else $error("box transaction with keypoint fields set");
`endif

endmodule

// ===== hw/rtl/abkd_queue.sv =====
// Two-entry queue of cell records between front and back.
module abkd_queue #(
  parameter int WIDTH = 419
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [WIDTH-1:0]      push_data,
  input  logic                  pop,
  output logic [WIDTH-1:0]      head,
  output abkd_pkg::queue_status_t status
);

  logic [WIDTH-1:0] mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head = mem[rd_ptr];
  assign status.full = (count == 2'd2);
  assign status.empty = (count == 2'd0);

endmodule

// ===== hw/rtl/abkd_front.sv =====
// Front: takes logits, tracks cell position and packs each finished cell into a record.
module abkd_front #(
  parameter int CHANNELS = 24,
  parameter int ANCHORS_PER_CELL = 3,
  parameter int IMAGE_SIZE = 640,
  parameter int REC_W = 419
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [15:0]      logit,
  input  logic             frame_start,
  input  logic [2:0]       stride_log2,
  input  logic [15:0]      score_thresh,
  input  logic             q_full,
  output logic             push,
  output logic [REC_W-1:0] rec
);

  localparam int CW = $clog2(CHANNELS);

  logic [15:0]   chan_buf [CHANNELS];
  logic [CW-1:0] ch;
  logic [6:0]    col;
  logic [6:0]    row;
  logic [1:0]    anc;

  logic          accept;
  logic [CW-1:0] ch_e;
  logic [6:0]    col_e;
  logic [6:0]    row_e;
  logic [1:0]    anc_e;
  logic [2:0]    sl_c;
  logic [9:0]    grid;
  logic          cell_end;

  assign in_stall = q_full;
  assign accept = in_valid & ~q_full;

  always_comb begin
    ch_e = frame_start ? '0 : ch;
    col_e = frame_start ? 7'd0 : col;
    row_e = frame_start ? 7'd0 : row;
    anc_e = frame_start ? 2'd0 : anc;
    if (stride_log2 < 3'd3) sl_c = 3'd3;
    else if (stride_log2 > 3'd5) sl_c = 3'd5;
    else sl_c = stride_log2;
    grid = 10'(IMAGE_SIZE) >> sl_c;
    cell_end = (ch_e == CW'(CHANNELS - 1));
  end

  assign push = accept & cell_end;

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      rec[35 + i*16 +: 16] = (i == CHANNELS - 1) ? logit : chan_buf[i];
    end
    rec[34:28] = col_e;
    rec[27:21] = row_e;
    rec[20:19] = anc_e;
    rec[18:16] = sl_c;
    rec[15:0] = score_thresh;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      chan_buf[ch_e] <= logit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch <= '0;
      col <= 7'd0;
      row <= 7'd0;
      anc <= 2'd0;
    end else if (accept) begin
      if (cell_end) begin
        ch <= '0;
        if ({3'd0, col_e} + 10'd1 >= grid) begin
          col <= 7'd0;
          if ({3'd0, row_e} + 10'd1 >= grid) begin
            row <= 7'd0;
            anc <= ({1'b0, anc_e} + 3'd1 >= 3'(ANCHORS_PER_CELL)) ? 2'd0 : anc_e + 2'd1;
          end else begin
            row <= row_e + 7'd1;
            anc <= anc_e;
          end
        end else begin
          col <= col_e + 7'd1;
          row <= row_e;
          anc <= anc_e;
        end
      end else begin
        ch <= ch_e + CW'(1);
        col <= col_e;
        row <= row_e;
        anc <= anc_e;
      end
    end
  end

endmodule

// ===== hw/rtl/abkd_back.sv =====
// Back: sequencer that scores a cell record and emits box and keypoint transactions.
module abkd_back #(
  parameter int CHANNELS = 24,
  parameter int CLASS_COUNT = 4,
  parameter int KEYPOINT_COUNT = 5,
  parameter int ANCHOR_SET = 2,
  parameter int REC_W = 419
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [REC_W-1:0]        rec,
  input  abkd_pkg::queue_status_t q_status,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    kind,
  output logic [19:0]             pos_x,
  output logic [19:0]             pos_y,
  output logic [14:0]             box_width,
  output logic [14:0]             box_height,
  output logic [3:0]              class_index,
  output logic [15:0]             confidence,
  output logic [2:0]              keypoint_index,
  output logic                    last
);

  localparam int CW = $clog2(CHANNELS);
  localparam int KP_BASE = 5 + CLASS_COUNT;

  abkd_pkg::back_state_t state, state_next;

  logic [15:0] vals [CHANNELS];
  logic [6:0]  col;
  logic [6:0]  row;
  logic [1:0]  anc;
  logic [2:0]  sl;
  logic [15:0] thr;

  logic [15:0]   obj;
  logic [15:0]   best;
  logic [3:0]    cls;
  logic [3:0]    cidx;
  logic [15:0]   conf;
  logic [15:0]   sx;
  logic [15:0]   sy;
  logic [16:0]   uw;
  logic [16:0]   uh;
  logic [33:0]   usq;
  logic [26:0]   wq;
  logic [26:0]   hq;
  logic signed [32:0] left;
  logic signed [32:0] top;
  logic [15:0]   lx;
  logic [15:0]   ly;
  logic [2:0]    kidx;
  logic [CW-1:0] sidx;

  logic [15:0] sig_in;
  logic [15:0] sig_out;
  logic [31:0] conf_prod;
  logic [8:0]  anc_w;
  logic [8:0]  anc_h;
  logic [42:0] scale_prod;
  logic signed [32:0] cx;
  logic signed [32:0] cy;
  logic signed [32:0] left_c;
  logic signed [32:0] top_c;
  logic signed [32:0] kx;
  logic signed [32:0] ky;
  logic        in_box;
  logic        slot_free;

  assign slot_free = ~out_valid | ~out_stall;

  // one shared sigmoid unit
  always_comb begin
    case (state)
      abkd_pkg::B_OBJ: sig_in = vals[4];
      abkd_pkg::B_CLS: sig_in = vals[sidx];
      abkd_pkg::B_SX:  sig_in = vals[0];
      abkd_pkg::B_SY:  sig_in = vals[1];
      abkd_pkg::B_SW:  sig_in = vals[2];
      abkd_pkg::B_SH:  sig_in = vals[3];
      default:         sig_in = vals[0];
    endcase
    sig_out = abkd_pkg::sigm(sig_in);
  end

  always_comb begin
    conf_prod = {16'd0, obj} * {16'd0, best};
    anc_w = abkd_pkg::ANCHOR_TAB[ANCHOR_SET][5'({2'd0, sl - 3'd3} * 5'd6 + {2'd0, anc, 1'b0})];
    anc_h = abkd_pkg::ANCHOR_TAB[ANCHOR_SET][5'({2'd0, sl - 3'd3} * 5'd6 + {2'd0, anc, 1'b1})];
    scale_prod = {9'd0, usq} * {34'd0, (state == abkd_pkg::B_W2) ? anc_w : anc_h};
    cx = ($signed({16'd0, sx, 1'b0}) - 33'sd32768 + $signed({10'd0, col, 16'd0})) <<< sl;
    cy = ($signed({16'd0, sy, 1'b0}) - 33'sd32768 + $signed({10'd0, row, 16'd0})) <<< sl;
    left_c = cx - $signed({7'd0, wq[26:1]});
    top_c = cy - $signed({7'd0, hq[26:1]});
    kx = ($signed({{8{lx[15]}}, lx, 9'd0}) - 33'sd32768 + $signed({10'd0, col, 16'd0})) <<< sl;
    ky = ($signed({{8{ly[15]}}, ly, 9'd0}) - 33'sd32768 + $signed({10'd0, row, 16'd0})) <<< sl;
    in_box = (kx > left) && (kx < left + $signed({6'd0, wq})) &&
             (ky > top) && (ky < top + $signed({6'd0, hq}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= abkd_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop = 1'b0;
    unique case (state)
      abkd_pkg::B_IDLE: begin
        if (!q_status.empty) begin
          pop = 1'b1;
          state_next = abkd_pkg::B_OBJ;
        end
      end
      abkd_pkg::B_OBJ: state_next = (sig_out < thr) ? abkd_pkg::B_IDLE : abkd_pkg::B_CLS;
      abkd_pkg::B_CLS: begin
        if (cidx == 4'(CLASS_COUNT - 1)) state_next = abkd_pkg::B_CONF;
      end
      abkd_pkg::B_CONF: begin
        state_next = (conf_prod[31:16] < thr) ? abkd_pkg::B_IDLE : abkd_pkg::B_SX;
      end
      abkd_pkg::B_SX: state_next = abkd_pkg::B_SY;
      abkd_pkg::B_SY: state_next = abkd_pkg::B_SW;
      abkd_pkg::B_SW: state_next = abkd_pkg::B_SH;
      abkd_pkg::B_SH: state_next = abkd_pkg::B_W1;
      abkd_pkg::B_W1: state_next = abkd_pkg::B_W2;
      abkd_pkg::B_W2: state_next = abkd_pkg::B_H1;
      abkd_pkg::B_H1: state_next = abkd_pkg::B_H2;
      abkd_pkg::B_H2: state_next = abkd_pkg::B_BOX;
      abkd_pkg::B_BOX: if (slot_free) state_next = abkd_pkg::B_KX;
      abkd_pkg::B_KX: state_next = abkd_pkg::B_KY;
      abkd_pkg::B_KY: state_next = abkd_pkg::B_KEMIT;
      abkd_pkg::B_KEMIT: begin
        if (slot_free) begin
          state_next = (kidx == 3'(KEYPOINT_COUNT - 1)) ? abkd_pkg::B_IDLE : abkd_pkg::B_KX;
        end
      end
      default: state_next = abkd_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      abkd_pkg::B_IDLE: begin
        for (int i = 0; i < CHANNELS; i++) begin
          vals[i] <= rec[35 + i*16 +: 16];
        end
        col <= rec[34:28];
        row <= rec[27:21];
        anc <= rec[20:19];
        sl <= rec[18:16];
        thr <= rec[15:0];
      end
      abkd_pkg::B_OBJ: begin
        obj <= sig_out;
        best <= 16'd0;
        cls <= 4'd0;
        cidx <= 4'd0;
        sidx <= CW'(5);
      end
      abkd_pkg::B_CLS: begin
        if (sig_out > best) begin
          best <= sig_out;
          cls <= cidx;
        end
        cidx <= cidx + 4'd1;
        sidx <= sidx + CW'(1);
      end
      abkd_pkg::B_CONF: begin
        conf <= conf_prod[31:16];
        sidx <= CW'(KP_BASE);
        kidx <= 3'd0;
      end
      abkd_pkg::B_SX: sx <= sig_out;
      abkd_pkg::B_SY: sy <= sig_out;
      abkd_pkg::B_SW: uw <= {sig_out, 1'b0};
      abkd_pkg::B_SH: uh <= {sig_out, 1'b0};
      abkd_pkg::B_W1: usq <= {17'd0, uw} * {17'd0, uw};
      abkd_pkg::B_W2: wq <= scale_prod[42:16];
      abkd_pkg::B_H1: usq <= {17'd0, uh} * {17'd0, uh};
      abkd_pkg::B_H2: hq <= scale_prod[42:16];
      abkd_pkg::B_BOX: begin
        left <= left_c;
        top <= top_c;
      end
      abkd_pkg::B_KX: begin
        lx <= vals[sidx];
        sidx <= sidx + CW'(1);
      end
      abkd_pkg::B_KY: begin
        ly <= vals[sidx];
        sidx <= sidx + CW'(2);
      end
      abkd_pkg::B_KEMIT: if (slot_free) kidx <= kidx + 3'd1;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == abkd_pkg::B_BOX && slot_free) begin
      out_valid <= 1'b1;
    end else if (state == abkd_pkg::B_KEMIT && slot_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == abkd_pkg::B_BOX && slot_free) begin
      kind <= 1'b0;
      pos_x <= abkd_pkg::sat_q4(left_c);
      pos_y <= abkd_pkg::sat_q4(top_c);
      box_width <= wq[26:12];
      box_height <= hq[26:12];
      class_index <= cls;
      confidence <= conf;
      keypoint_index <= 3'd0;
      last <= 1'b0;
    end else if (state == abkd_pkg::B_KEMIT && slot_free) begin
      kind <= 1'b1;
      if (kidx != abkd_pkg::KP_ALWAYS_KEPT && !in_box) begin
        pos_x <= 20'd0;
        pos_y <= 20'd0;
      end else begin
        pos_x <= abkd_pkg::sat_q4(kx);
        pos_y <= abkd_pkg::sat_q4(ky);
      end
      box_width <= 15'd0;
      box_height <= 15'd0;
      class_index <= cls;
      confidence <= conf;
      keypoint_index <= kidx;
      last <= (kidx == 3'(KEYPOINT_COUNT - 1));
    end
  end

endmodule

// ===== tb/tb_anchor_box_keypoint_decode.sv =====
// Self-checking testbench for the pose head decoder: random stimulus, predictor, checker.
`timescale 1ns / 1ps
module tb_anchor_box_keypoint_decode;

  localparam int CHANNELS = 24;
  localparam int CLASSES = 4;
  localparam int KEYPOINTS = 5;
  localparam int ANCHORS = 3;
  localparam int IMG = 640;
  localparam int ANCHOR_SET = 2;
  localparam int SETTLE = 80;

  typedef enum int {CELL_NOISE, CELL_POSE, CELL_MAX, CELL_MIN, CELL_TIE} cell_mode_t;

  typedef struct {
    logic [15:0] logit;
    logic        fs;
  } logit_item_t;

  typedef struct {
    logic        kind;
    logic [19:0] px;
    logic [19:0] py;
    logic [14:0] w;
    logic [14:0] h;
    logic [3:0]  cls;
    logic [15:0] conf;
    logic [2:0]  kp;
    logic        last;
  } detection_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_index = abkd_pkg::CFG_STRIDE;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] logit = '0;
  logic frame_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic kind;
  logic [19:0] pos_x, pos_y;
  logic [14:0] box_width, box_height;
  logic [3:0] class_index;
  logic [15:0] confidence;
  logic [2:0] keypoint_index;
  logic last;

  anchor_box_keypoint_decode uut (.*);

  always #1 clk = ~clk;

  logit_item_t pending_logits[$];
  detection_t expected_dets[$];
  int errors = 0;
  logic tx_burst = 1'b0;
  logic rx_burst = 1'b0;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int hold_left = 0;
  int gap_left = 0;
  int stall_left = 0;

  // shadow of the block's state
  logic [15:0] cell_buf[CHANNELS];
  int unsigned chan_pos = 0, col_pos = 0, row_pos = 0, anc_pos = 0;
  logic [2:0] stride_reg = 3'd3;
  logic [15:0] thresh_reg = 16'd32768;

  function automatic int unsigned sig_q16(logic [15:0] raw);
    int v;
    int unsigned a, i, p;
    v = $signed(raw);
    a = v < 0 ? -v : v;
    i = a >> 7;
    if (i >= 24) p = 65535;
    else p = abkd_pkg::SIG_TAB[i] + (((int'(abkd_pkg::SIG_TAB[i + 1]) -
             int'(abkd_pkg::SIG_TAB[i])) * (a & 127)) >> 7);
    return v < 0 ? 65536 - p : p;
  endfunction

  function automatic logic [19:0] to_q4(longint v);
    longint r;
    r = v >>> 12;
    if (r > 524287) r = 524287;
    if (r < -524288) r = -524288;
    return r[19:0];
  endfunction

  function automatic void add_det(logic k, longint x16, longint y16, longint w16,
                                  longint h16, int cls, int conf, int kp, logic lst);
    detection_t d;
    longint w, h;
    w = w16 >>> 12;
    h = h16 >>> 12;
    d.kind = k;
    d.px = to_q4(x16);
    d.py = to_q4(y16);
    d.w = (w > 32767) ? 15'h7FFF : w[14:0];
    d.h = (h > 32767) ? 15'h7FFF : h[14:0];
    d.cls = cls[3:0];
    d.conf = conf[15:0];
    d.kp = kp[2:0];
    d.last = lst;
    expected_dets.insert(expected_dets.size(), d);
  endfunction

  function automatic void decode_pose(int sl);
    int unsigned obj, best, cls, conf, p, aw, ah;
    longint stride, colq, rowq, cx, cy, u, wq, hq, left, top, kx, ky;
    int base;
    logic in_box;
    obj = sig_q16(cell_buf[4]);
    best = 0;
    cls = 0;
    if (obj < thresh_reg) return;
    for (int c = 0; c < CLASSES; c++) begin
      p = sig_q16(cell_buf[5 + c]);
      if (p > best) begin
        best = p;
        cls = c;
      end
    end
    conf = 32'((longint'(obj) * best) >> 16);
    if (conf > 65535) conf = 65535;
    if (conf < thresh_reg) return;
    stride = longint'(1) << sl;
    colq = longint'(col_pos) * 65536;
    rowq = longint'(row_pos) * 65536;
    aw = abkd_pkg::ANCHOR_TAB[ANCHOR_SET][(sl - 3) * 6 + (anc_pos % 3) * 2];
    ah = abkd_pkg::ANCHOR_TAB[ANCHOR_SET][(sl - 3) * 6 + (anc_pos % 3) * 2 + 1];
    cx = (2 * longint'(sig_q16(cell_buf[0])) - 32768 + colq) * stride;
    cy = (2 * longint'(sig_q16(cell_buf[1])) - 32768 + rowq) * stride;
    u = 2 * longint'(sig_q16(cell_buf[2]));
    wq = (u * u * aw) >> 16;
    u = 2 * longint'(sig_q16(cell_buf[3]));
    hq = (u * u * ah) >> 16;
    left = cx - (wq >> 1);
    top = cy - (hq >> 1);
    add_det(1'b0, left, top, wq, hq, cls, conf, 0, 1'b0);
    for (int k = 0; k < KEYPOINTS; k++) begin
      base = 5 + CLASSES + 3 * k;
      kx = (longint'($signed(cell_buf[base])) * 512 - 32768 + colq) * stride;
      ky = (longint'($signed(cell_buf[base + 1])) * 512 - 32768 + rowq) * stride;
      in_box = kx > left && kx < left + wq && ky > top && ky < top + hq;
      if (k != abkd_pkg::KP_ALWAYS_KEPT && !in_box) begin
        kx = 0;
        ky = 0;
      end
      add_det(1'b1, kx, ky, 0, 0, cls, conf, k, k == KEYPOINTS - 1);
    end
  endfunction

  function automatic void predict_logit(logic [15:0] lg, logic fs);
    int sl, grid;
    sl = stride_reg < 3 ? 3 : (stride_reg > 5 ? 5 : stride_reg);
    grid = IMG >> sl;
    if (fs) begin
      chan_pos = 0;
      col_pos = 0;
      row_pos = 0;
      anc_pos = 0;
    end
    if (chan_pos >= CHANNELS) chan_pos = 0;
    cell_buf[chan_pos] = lg;
    if (chan_pos + 1 >= CHANNELS) begin
      decode_pose(sl);
      chan_pos = 0;
      col_pos++;
      if (col_pos >= grid) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= grid) begin
          row_pos = 0;
          anc_pos++;
          if (anc_pos >= ANCHORS) anc_pos = 0;
        end
      end
      col_pos &= 127;
      row_pos &= 127;
    end else begin
      chan_pos++;
    end
  endfunction

  function automatic int draw_wait(logic burst);
    if (burst) return 0;
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
  endfunction

  // sender
  always @(posedge clk) begin
    logit_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_logit(logit, frame_start);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_logits.size() > 0) begin
          it = pending_logits.pop_front();
          in_valid <= 1'b1;
          logit <= it.logit;
          frame_start <= it.fs;
          gap_left <= draw_wait(tx_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, longint e, longint a);
    if (e != a) begin
      $error("%s expected %0h actual %0h", name, e, a);
      errors++;
    end
  endfunction

  // receiver and checker
  always @(posedge clk) begin
    detection_t d;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_dets.size() == 0) begin
          $error("unexpected result transaction");
          errors++;
        end else begin
          d = expected_dets.pop_front();
          check_field("kind", d.kind, kind);
          check_field("pos_x", d.px, pos_x);
          check_field("pos_y", d.py, pos_y);
          check_field("box_width", d.w, box_width);
          check_field("box_height", d.h, box_height);
          check_field("class_index", d.cls, class_index);
          check_field("confidence", d.conf, confidence);
          check_field("keypoint_index", d.kp, keypoint_index);
          check_field("last", d.last, last);
        end
      end
      if (hold_req != hold_ack) begin
        hold_ack <= hold_req;
        hold_left <= 400;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (out_valid && !out_stall) stall_left <= draw_wait(rx_burst);
      end
    end
  end

  task automatic add_logit(logic [15:0] v, logic fs);
    logit_item_t it;
    it.logit = v;
    it.fs = fs;
    pending_logits.insert(pending_logits.size(), it);
  endtask

  function automatic logic [15:0] near_zero();
    return 16'($signed($urandom_range(0, 1536)) - 768);
  endfunction

  task automatic add_cell(cell_mode_t mode, logic fs);
    logic [15:0] v[CHANNELS];
    int hot;
    for (int c = 0; c < CHANNELS; c++) v[c] = 16'($urandom);
    case (mode)
      CELL_MAX: for (int c = 0; c < CHANNELS; c++) v[c] = 16'h7FFF;
      CELL_MIN: for (int c = 0; c < CHANNELS; c++) v[c] = 16'h8000;
      CELL_POSE, CELL_TIE: begin
        for (int c = 0; c < 4; c++) v[c] = near_zero();
        v[4] = 16'($urandom_range(16'h0100, 16'h7FFF));
        hot = $urandom_range(0, CLASSES - 1);
        for (int c = 0; c < CLASSES; c++)
          v[5 + c] = (mode == CELL_TIE) ? 16'h0500 : near_zero();
        if (mode == CELL_POSE) v[5 + hot] = 16'($urandom_range(16'h0200, 16'h7FFF));
        for (int k = 0; k < KEYPOINTS; k++) begin
          v[9 + 3 * k] = ($urandom_range(0, 3) == 0) ? near_zero() :
                         16'($urandom_range(40, 220));
          v[10 + 3 * k] = ($urandom_range(0, 3) == 0) ? near_zero() :
                          16'($urandom_range(40, 220));
        end
      end
      default: ;
    endcase
    for (int c = 0; c < CHANNELS; c++) add_logit(v[c], (c == 0) ? fs : 1'b0);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == abkd_pkg::CFG_STRIDE) stride_reg = data[2:0];
    else thresh_reg = data;
  endtask

  task automatic wait_drained();
    while (pending_logits.size() > 0 || in_valid || expected_dets.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings; four kept cells back to back under a long output hold-off
    // fill the back, the queue and then stall the input
    tx_burst = 1'b1;
    add_cell(CELL_POSE, 1'b1);
    add_cell(CELL_MAX, 1'b0);
    add_cell(CELL_TIE, 1'b0);
    add_cell(CELL_POSE, 1'b0);
    @(posedge clk);
    hold_req <= ~hold_req;
    wait_drained();
    tx_burst = 1'b0;

    // stride below range, zero threshold keeps every cell
    write_reg(abkd_pkg::CFG_STRIDE, 16'd0);
    write_reg(abkd_pkg::CFG_THRESH, 16'd0);
    add_cell(CELL_MIN, 1'b1);
    wait_drained();

    // stride above range; a stray partial run, then a fresh frame
    write_reg(abkd_pkg::CFG_STRIDE, 16'd7);
    write_reg(abkd_pkg::CFG_THRESH, 16'd40000);
    repeat ($urandom_range(1, 7)) add_logit(16'($urandom), $urandom_range(0, 3) == 0);
    add_cell(CELL_POSE, 1'b1);
    add_cell(CELL_NOISE, 1'b0);
    wait_drained();

    // top threshold: saturated objectness passes, confidence fails
    write_reg(abkd_pkg::CFG_STRIDE, 16'd4);
    write_reg(abkd_pkg::CFG_THRESH, 16'hFFFF);
    add_cell(CELL_MAX, 1'b1);
    wait_drained();

    if (errors == 0) begin
      $display("tb_anchor_box_keypoint_decode passed");
    end else begin
      $display("tb_anchor_box_keypoint_decode failed");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("tb_anchor_box_keypoint_decode failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/abkd_pkg.sv
hw/rtl/abkd_queue.sv
hw/rtl/abkd_front.sv
hw/rtl/abkd_back.sv
hw/rtl/anchor_box_keypoint_decode.sv
tb/tb_anchor_box_keypoint_decode.sv
